/* rtl/ucfs_pkg.sv */
// ----------------------------------------------------------------------------
// ucfs_pkg
// Shared types and codes for the unwind-code frame-size unit.
// ----------------------------------------------------------------------------
package ucfs_pkg;

    // command codes carried by an input item
    localparam logic [1:0] CMD_BEGIN  = 2'd0;
    localparam logic [1:0] CMD_SLOT   = 2'd1;
    localparam logic [1:0] CMD_FINISH = 2'd2;

    // unwind opcodes (slot bits 11:8)
    localparam logic [3:0] OP_PUSH       = 4'd0;
    localparam logic [3:0] OP_ALLOC_LRG  = 4'd1;
    localparam logic [3:0] OP_ALLOC_SML  = 4'd2;
    localparam logic [3:0] OP_SET_FP     = 4'd3;
    localparam logic [3:0] OP_SAVE       = 4'd4;
    localparam logic [3:0] OP_SAVE_FAR   = 4'd5;

    // kind of operand slot still expected
    localparam logic [2:0] KIND_NONE    = 3'd0;
    localparam logic [2:0] KIND_SKIP1   = 3'd1;
    localparam logic [2:0] KIND_SKIP2   = 3'd2;
    localparam logic [2:0] KIND_LARGE8  = 3'd3;
    localparam logic [2:0] KIND_LARGELO = 3'd4;
    localparam logic [2:0] KIND_LARGEHI = 3'd5;

    // register number of the base pointer
    localparam logic [3:0] BASE_PTR_REG = 4'h5;

    // bytes per stack slot and for the return address
    localparam logic [31:0] SLOT_BYTES = 32'd8;

    typedef struct packed {
        logic [1:0]  command;
        logic [15:0] code_slot;
        logic [7:0]  record_code_count;
    } item_t;

    typedef struct packed {
        logic [31:0] frame_size;
        logic        status;
        logic        sets_frame_pointer;
        logic        pushes_base_pointer;
        logic [7:0]  push_position;
        logic [7:0]  push_record_count;
    } result_t;

    // handshake between the stages
    typedef struct packed {
        logic take;
        logic emit;
    } stage_ctl_t;

endpackage

/* rtl/ucfs_if.sv */
// ----------------------------------------------------------------------------
// ucfs_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface ucfs_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [15:0] code_slot;
    logic [7:0]  record_code_count;

    modport source (output valid, command, code_slot, record_code_count, input ready);
    modport sink   (input valid, command, code_slot, record_code_count, output ready);
endinterface

interface ucfs_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] frame_size;
    logic        status;
    logic        sets_frame_pointer;
    logic        pushes_base_pointer;
    logic [7:0]  push_position;
    logic [7:0]  push_record_count;

    modport source (output valid, frame_size, status, sets_frame_pointer,
                    pushes_base_pointer, push_position, push_record_count,
                    input ready);
    modport sink   (input valid, frame_size, status, sets_frame_pointer,
                    pushes_base_pointer, push_position, push_record_count,
                    output ready);
endinterface

/* rtl/unwind_code_frame_size_unit.sv */
// ----------------------------------------------------------------------------
// unwind_code_frame_size_unit
// Sums the stack space described by a stream of x64 unwind-code slots.
// ----------------------------------------------------------------------------
// Feed a begin item with the record's code count, then its slots one item
// each, optionally further chained records, then a finish item; the finish
// item yields one result with the frame size (return address included when
// no unsupported opcode was seen), the flags and the status, and clears the
// walk. Every item is held in the input register while the decode logic
// applies it, so one item is accepted per clock unless a finish item waits,
// and the result of a finish item is registered in the result register.
// A finish item waits in the input register only while an earlier result is
// still held, and no further item is accepted while it waits.
module unwind_code_frame_size_unit
    import ucfs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    ucfs_in_if.sink     in_ch,
    ucfs_out_if.source  out_ch
);

    logic       item_vld;
    item_t      item;
    logic       out_free;
    stage_ctl_t ctl;
    result_t    result;

    // input register
    ucfs_in_stage u_in_stage (
        .clk   (clk),
        .rst_n (rst_n),
        .in_ch (in_ch),
        .take  (ctl.take),
        .vld   (item_vld),
        .item  (item)
    );

    // decode and walk state
    ucfs_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .vld      (item_vld),
        .item     (item),
        .out_free (out_free),
        .ctl      (ctl),
        .result   (result)
    );

    // result register
    ucfs_out_stage u_out_stage (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (ctl.emit),
        .data   (result),
        .free   (out_free),
        .out_ch (out_ch)
    );

endmodule

/* rtl/ucfs_in_stage.sv */
// ----------------------------------------------------------------------------
// ucfs_in_stage
// Input register: holds one item until the walker takes it.
// ----------------------------------------------------------------------------
module ucfs_in_stage
    import ucfs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    ucfs_in_if.sink     in_ch,
    input  logic        take,
    output logic        vld,
    output item_t       item
);

    logic  vld_reg;
    logic  vld_next;
    item_t item_reg;

    // room when empty or when the held item leaves this cycle
    assign in_ch.ready = !vld_reg || take;
    assign vld_next    = in_ch.valid || (vld_reg && !take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // payload load on accept
    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            item_reg.command           <= in_ch.command;
            item_reg.code_slot         <= in_ch.code_slot;
            item_reg.record_code_count <= in_ch.record_code_count;
        end
    end

    assign vld  = vld_reg;
    assign item = item_reg;

endmodule

/* rtl/ucfs_core.sv */
// ----------------------------------------------------------------------------
// ucfs_core
// Walk state and per-item decode: one item per cycle, unless a finish waits.
// ----------------------------------------------------------------------------
module ucfs_core
    import ucfs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       vld,
    input  item_t      item,
    input  logic       out_free,
    output stage_ctl_t ctl,
    output result_t    result
);

    logic [31:0] running_size_reg, running_size_next;
    logic [7:0]  slot_position_reg, slot_position_next;
    logic [7:0]  record_count_reg, record_count_next;
    logic [2:0]  pending_kind_reg, pending_kind_next;
    logic [15:0] low_half_reg, low_half_next;
    logic        fp_flag_reg, fp_flag_next;
    logic        push_flag_reg, push_flag_next;
    logic [7:0]  push_index_reg, push_index_next;
    logic [7:0]  push_count_reg, push_count_next;
    logic        error_reg, error_next;

    logic [3:0]  opcode;
    logic [3:0]  info;

    assign opcode = item.code_slot[11:8];
    assign info   = item.code_slot[15:12];

    // a finish item waits for room in the result register
    assign ctl.take = vld && ((item.command != CMD_FINISH) || out_free);
    assign ctl.emit = ctl.take && (item.command == CMD_FINISH);

    // result of a finish item
    always_comb
    begin
        result.frame_size          = error_reg ? running_size_reg
                                               : running_size_reg + SLOT_BYTES;
        result.status              = error_reg;
        result.sets_frame_pointer  = fp_flag_reg;
        result.pushes_base_pointer = push_flag_reg;
        result.push_position       = push_index_reg;
        result.push_record_count   = push_count_reg;
    end

    // next state for the item in the input register
    always_comb
    begin
        running_size_next  = running_size_reg;
        slot_position_next = slot_position_reg;
        record_count_next  = record_count_reg;
        pending_kind_next  = pending_kind_reg;
        low_half_next      = low_half_reg;
        fp_flag_next       = fp_flag_reg;
        push_flag_next     = push_flag_reg;
        push_index_next    = push_index_reg;
        push_count_next    = push_count_reg;
        error_next         = error_reg;

        if (ctl.take)
        begin
            case (item.command)
                CMD_BEGIN:
                begin
                    record_count_next  = item.record_code_count;
                    slot_position_next = 8'd0;
                    pending_kind_next  = KIND_NONE;
                    low_half_next      = 16'd0;
                end
                CMD_SLOT:
                begin
                    if (!error_reg)
                    begin
                        if (pending_kind_reg != KIND_NONE)
                        begin
                            // operand slot, consumed even past the count
                            slot_position_next = slot_position_reg + 8'd1;
                            case (pending_kind_reg)
                                KIND_SKIP2:
                                begin
                                    pending_kind_next = KIND_SKIP1;
                                end
                                KIND_LARGE8:
                                begin
                                    running_size_next = running_size_reg
                                        + {13'd0, item.code_slot, 3'd0};
                                    pending_kind_next = KIND_NONE;
                                end
                                KIND_LARGELO:
                                begin
                                    low_half_next     = item.code_slot;
                                    pending_kind_next = KIND_LARGEHI;
                                end
                                KIND_LARGEHI:
                                begin
                                    running_size_next = running_size_reg
                                        + {item.code_slot, low_half_reg};
                                    pending_kind_next = KIND_NONE;
                                end
                                default:
                                begin
                                    pending_kind_next = KIND_NONE;
                                end
                            endcase
                        end
                        else if (slot_position_reg < record_count_reg)
                        begin
                            // opcode slot inside the record
                            slot_position_next = slot_position_reg + 8'd1;
                            case (opcode)
                                OP_PUSH:
                                begin
                                    running_size_next = running_size_reg + SLOT_BYTES;
                                    if (info == BASE_PTR_REG)
                                    begin
                                        push_flag_next  = 1'b1;
                                        push_count_next = record_count_reg;
                                        push_index_next = slot_position_reg + 8'd1;
                                    end
                                end
                                OP_ALLOC_LRG:
                                begin
                                    pending_kind_next = (info == 4'd0) ? KIND_LARGE8
                                                                       : KIND_LARGELO;
                                end
                                OP_ALLOC_SML:
                                begin
                                    running_size_next = running_size_reg
                                        + {25'd0, info, 3'd0} + SLOT_BYTES;
                                end
                                OP_SET_FP:
                                begin
                                    fp_flag_next = 1'b1;
                                end
                                OP_SAVE:
                                begin
                                    pending_kind_next = KIND_SKIP1;
                                end
                                OP_SAVE_FAR:
                                begin
                                    pending_kind_next = KIND_SKIP2;
                                end
                                default:
                                begin
                                    error_next = 1'b1;
                                end
                            endcase
                        end
                    end
                end
                CMD_FINISH:
                begin
                    running_size_next  = 32'd0;
                    slot_position_next = 8'd0;
                    record_count_next  = 8'd0;
                    pending_kind_next  = KIND_NONE;
                    low_half_next      = 16'd0;
                    fp_flag_next       = 1'b0;
                    push_flag_next     = 1'b0;
                    push_index_next    = 8'd0;
                    push_count_next    = 8'd0;
                    error_next         = 1'b0;
                end
                default:
                begin
                    // unused command: no effect
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_size_reg  <= 32'd0;
            slot_position_reg <= 8'd0;
            record_count_reg  <= 8'd0;
            pending_kind_reg  <= KIND_NONE;
            low_half_reg      <= 16'd0;
            fp_flag_reg       <= 1'b0;
            push_flag_reg     <= 1'b0;
            push_index_reg    <= 8'd0;
            push_count_reg    <= 8'd0;
            error_reg         <= 1'b0;
        end
        else
        begin
            running_size_reg  <= running_size_next;
            slot_position_reg <= slot_position_next;
            record_count_reg  <= record_count_next;
            pending_kind_reg  <= pending_kind_next;
            low_half_reg      <= low_half_next;
            fp_flag_reg       <= fp_flag_next;
            push_flag_reg     <= push_flag_next;
            push_index_reg    <= push_index_next;
            push_count_reg    <= push_count_next;
            error_reg         <= error_next;
        end
    end

endmodule

/* rtl/ucfs_out_stage.sv */
// ----------------------------------------------------------------------------
// ucfs_out_stage
// Result register: holds one result item until the sink takes it.
// ----------------------------------------------------------------------------
module ucfs_out_stage
    import ucfs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  result_t     data,
    output logic        free,
    ucfs_out_if.source  out_ch
);

    logic    vld_reg;
    logic    vld_next;
    result_t data_reg;

    // free when empty or when the held result leaves this cycle
    assign free     = !vld_reg || out_ch.ready;
    assign vld_next = load || (vld_reg && !out_ch.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= data;
        end
    end

    // drive the channel
    assign out_ch.valid               = vld_reg;
    assign out_ch.frame_size          = data_reg.frame_size;
    assign out_ch.status              = data_reg.status;
    assign out_ch.sets_frame_pointer  = data_reg.sets_frame_pointer;
    assign out_ch.pushes_base_pointer = data_reg.pushes_base_pointer;
    assign out_ch.push_position       = data_reg.push_position;
    assign out_ch.push_record_count   = data_reg.push_record_count;

endmodule
